@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher: queue item,
// back-end states, compression control bundle, round constants and initial
// hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

  // input queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // byte positions inside one 64-byte block
  localparam logic [5:0] LastFill  = 6'd63;
  localparam logic [5:0] LenFill   = 6'd56;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWordIdx = 3'd7;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [63:0] ByteBits = 64'd8;

  // beat kind as seen by the back end
  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUNDS,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // controls from the sequencer to the compression unit
  typedef struct packed {
    logic       push;
    logic       start;
    logic       round;
    logic       fold;
    logic       reinit;
    logic [5:0] round_idx;
    logic [2:0] rd_idx;
  } cmp_ctrl_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // rotate right by a constant amount
  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

@@ src/sha_in_queue.sv @@
// ----------------------------------------------------------------------------
// sha_in_queue
// Front end: takes input beats, tags them as absorb or finish and holds them
// in a short queue so the back end can stall on its own.
// ----------------------------------------------------------------------------
module sha_in_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [7:0]          in_data_byte,
  output logic                q_valid,
  output sha_pkg::item_t      q_item,
  input  logic                q_pop
);

  sha_pkg::item_t                 mem_r [sha_pkg::QDepth];
  logic [sha_pkg::QPtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sha_pkg::QPtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sha_pkg::QPtrW:0]        count_r, count_nxt;
  logic                           push;
  logic                           pop;
  sha_pkg::item_t                 new_item;

  // classify the incoming beat
  always_comb begin
    new_item.cmd  = in_mode ? sha_pkg::CMD_FINISH : sha_pkg::CMD_ABSORB;
    new_item.data = in_data_byte;
  end

  assign in_ready = (count_r != (sha_pkg::QPtrW + 1)'(sha_pkg::QDepth));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

@@ src/sha_compress.sv @@
// ----------------------------------------------------------------------------
// sha_compress
// Compression unit: 16-word message schedule shift line, eight working
// words with one round per cycle, and the eight hash words.
// ----------------------------------------------------------------------------
module sha_compress (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::cmp_ctrl_t   ctl,
  input  logic [31:0]          push_word,
  output logic [31:0]          hash_word
);

  logic [31:0] hash_r  [8];
  logic [31:0] work_r  [8];
  logic [31:0] sched_r [16];
  logic [31:0] work_nxt [8];
  logic [31:0] sched_in;

  assign hash_word = hash_r[ctl.rd_idx];

  // one round and the next schedule word
  always_comb begin
    logic [31:0] s0, s1, ch, mj, t1, t2, g0, g1, w15, w2;
    w15 = sched_r[1];
    w2  = sched_r[14];
    g0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    g1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    s1  = sha_pkg::rotr(work_r[4], 6) ^ sha_pkg::rotr(work_r[4], 11)
        ^ sha_pkg::rotr(work_r[4], 25);
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1  = work_r[7] + s1 + ch + sha_pkg::RoundK[ctl.round_idx] + sched_r[0];
    s0  = sha_pkg::rotr(work_r[0], 2) ^ sha_pkg::rotr(work_r[0], 13)
        ^ sha_pkg::rotr(work_r[0], 22);
    mj  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2  = s0 + mj;
    work_nxt[7] = work_r[6];
    work_nxt[6] = work_r[5];
    work_nxt[5] = work_r[4];
    work_nxt[4] = work_r[3] + t1;
    work_nxt[3] = work_r[2];
    work_nxt[2] = work_r[1];
    work_nxt[1] = work_r[0];
    work_nxt[0] = t1 + t2;
    sched_in = ctl.push ? push_word : (sched_r[0] + g0 + sched_r[9] + g1);
  end

  // schedule shift line: filled with message words, then rolled each round
  always_ff @(posedge clk) begin
    if (ctl.push || ctl.round) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= sched_in;
    end
  end

  // working words
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= hash_r[i];
      end
    end else if (ctl.round) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= work_nxt[i];
      end
    end
  end

  // hash words: initial values, or folded with the working words
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.reinit) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha_pkg::InitHash[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + work_r[i];
      end
    end
  end

endmodule

@@ src/sha_back_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_back_ctrl
// Back-end sequencer: packs bytes into schedule words, counts length,
// pads the final block, steps the rounds and emits the digest words.
// ----------------------------------------------------------------------------
module sha_back_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  sha_pkg::item_t       q_item,
  output logic                 q_pop,
  output sha_pkg::cmp_ctrl_t   ctl,
  output logic [31:0]          push_word,
  input  logic [31:0]          hash_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);

  sha_pkg::state_t state_r, state_nxt;
  sha_pkg::state_t resume_r, resume_nxt;
  logic [5:0]      fill_r, fill_nxt;
  logic [63:0]     len_r, len_nxt;
  logic [23:0]     acc_r, acc_nxt;
  logic [5:0]      round_r, round_nxt;
  logic [2:0]      emit_idx_r, emit_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_word_r, out_word_nxt;
  logic [2:0]      out_idx_r, out_idx_nxt;
  logic            out_last_r, out_last_nxt;
  logic            push_byte;
  logic [7:0]      byte_val;
  sha_pkg::state_t next_phase;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;
  assign push_word       = {acc_r, byte_val};

  // next state and controls
  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    acc_nxt       = acc_r;
    round_nxt     = round_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    push_byte     = 1'b0;
    byte_val      = sha_pkg::ZeroByte;
    next_phase    = sha_pkg::ST_IDLE;
    ctl           = '0;

    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.cmd == sha_pkg::CMD_ABSORB) begin
            push_byte  = 1'b1;
            byte_val   = q_item.data;
            len_nxt    = len_r + sha_pkg::ByteBits;
            next_phase = sha_pkg::ST_IDLE;
          end else begin
            state_nxt = sha_pkg::ST_PAD_ONE;
          end
        end
      end
      sha_pkg::ST_PAD_ONE: begin
        push_byte  = 1'b1;
        byte_val   = sha_pkg::PadByte;
        next_phase = sha_pkg::ST_PAD_ZERO;
        state_nxt  = sha_pkg::ST_PAD_ZERO;
      end
      sha_pkg::ST_PAD_ZERO: begin
        if (fill_r == sha_pkg::LenFill) begin
          state_nxt = sha_pkg::ST_PAD_LEN;
        end else begin
          push_byte  = 1'b1;
          next_phase = sha_pkg::ST_PAD_ZERO;
        end
      end
      sha_pkg::ST_PAD_LEN: begin
        // length goes out most significant byte first and drains to zero
        push_byte  = 1'b1;
        byte_val   = len_r[63:56];
        len_nxt    = {len_r[55:0], sha_pkg::ZeroByte};
        next_phase = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_ROUNDS: begin
        ctl.round     = 1'b1;
        ctl.round_idx = round_r;
        round_nxt     = round_r + 6'd1;
        if (round_r == sha_pkg::LastRound) begin
          state_nxt = sha_pkg::ST_FOLD;
        end
      end
      sha_pkg::ST_FOLD: begin
        ctl.fold  = 1'b1;
        state_nxt = resume_r;
      end
      sha_pkg::ST_EMIT: begin
        ctl.rd_idx = emit_idx_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hash_word;
          out_idx_nxt   = emit_idx_r;
          out_last_nxt  = (emit_idx_r == sha_pkg::LastWordIdx);
          emit_idx_nxt  = emit_idx_r + 3'd1;
          if (emit_idx_r == sha_pkg::LastWordIdx) begin
            ctl.reinit = 1'b1;
            state_nxt  = sha_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha_pkg::ST_IDLE;
      end
    endcase

    // shared byte path: pack bytes, hand over whole words, start on full block
    if (push_byte) begin
      acc_nxt  = {acc_r[15:0], byte_val};
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'b11) begin
        ctl.push = 1'b1;
      end
      if (fill_r == sha_pkg::LastFill) begin
        ctl.start  = 1'b1;
        round_nxt  = '0;
        resume_nxt = next_phase;
        state_nxt  = sha_pkg::ST_ROUNDS;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_IDLE;
      resume_r    <= sha_pkg::ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      round_r     <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      round_r     <= round_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ src/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream: absorb beats add bytes, a finish beat pads,
// compresses and returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Beats wait in a four-entry input queue while the back end is busy.
// Every 64th byte starts a compression of 64 rounds, one per cycle in the
// single round unit, followed by the hash fold; the back end takes no new
// bytes until the fold is done. A finish beat leaves the queue, then the
// padding and length bytes go in up to the end of the block (64 minus the
// pending byte count), with one idle step where the zero fill meets the
// length field. When more than 55 bytes are pending, the first block closes
// after its zero fill and is compressed, and a second block of 56 zero
// bytes, that idle step and the 8 length bytes follows. The last block is
// then compressed and the eight digest words go out from word 0, one per
// cycle while out_ready is high. The block is back at the initial hash
// values as soon as the last word is loaded into the output register, and
// input beats keep being queued while digest words wait.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic               q_valid;
  logic               q_pop;
  sha_pkg::item_t     q_item;
  sha_pkg::cmp_ctrl_t ctl;
  logic [31:0]        push_word;
  logic [31:0]        hash_word;

  // front end: classify and queue input beats
  sha_in_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back end: sequencer and output register
  sha_back_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .ctl             (ctl),
    .push_word       (push_word),
    .hash_word       (hash_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // back end: schedule, rounds and hash words
  sha_compress u_compress (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_word (push_word),
    .hash_word (hash_word)
  );

endmodule

@@ src/sha_port_checker.sv @@
// ----------------------------------------------------------------------------
// sha_port_checker
// Port-level checks on the hasher: reset state, result beat ordering and
// the result hold while stalled.
// ----------------------------------------------------------------------------
module sha_port_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word
);

  // after reset no result is shown and the queue has room
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("hasher not idle after reset");

  // the last-word flag marks exactly the final digest word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == sha_pkg::LastWordIdx)))
    else $error("last word flag does not match word index");

  // a taken non-final word is followed by the next index
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      !out_valid || (out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest words out of order");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_digest_word) && $stable(out_word_index))
    else $error("result beat changed while stalled");

endmodule

bind sha256_stream_hasher sha_port_checker u_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

@@ verif/sha256_stream_hasher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test
// Self-checking bench for the SHA-256 stream hasher. Byte and finish beats
// go in under random bursts and gaps while the digest side stalls on its
// own pattern; a software SHA-256 alongside works out every digest word,
// and each word that leaves the block is checked against it.
// ----------------------------------------------------------------------------

// round constants, first 32 bits of the fractional cube roots of the primes
localparam logic [31:0] RoundConst [64] = '{
  32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
  32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
  32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
  32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
  32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
  32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
  32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
  32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
  32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
  32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
  32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
};

// chaining value at the start of every message
localparam logic [31:0] IvWords [8] = '{
  32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
  32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
};

typedef struct packed {
  logic [31:0] word;
  logic [2:0]  idx;
  logic        last;
} digest_word_t;

class digest_scoreboard;
  logic [31:0]  chain [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill;
  logic [63:0]  msg_bits;
  digest_word_t pending_words [$];
  int unsigned  errors;
  int unsigned  words_checked;

  function new();
    errors = 0;
    words_checked = 0;
    restart();
  endfunction

  function void restart();
    chain = IvWords;
    fill = 0;
    msg_bits = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int n);
    logic [63:0] twice;
    twice = {v, v} >> n;
    return twice[31:0];
  endfunction

  // one 64-round compression of block_bytes into the chaining value
  function void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
    {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = w[t & 15]
           + (ror(w[(t-15) & 15], 7) ^ ror(w[(t-15) & 15], 18) ^ (w[(t-15) & 15] >> 3))
           + w[(t-7) & 15]
           + (ror(w[(t-2) & 15], 17) ^ ror(w[(t-2) & 15], 19) ^ (w[(t-2) & 15] >> 10));
        w[t & 15] = wt;
      end
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RoundConst[t] + wt;
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  // accepted input beat: absorb a byte, or pad, close and queue the digest
  function void note_beat(sha_pkg::cmd_t mode, logic [7:0] data);
    int j;
    digest_word_t dw;
    if (mode == sha_pkg::CMD_ABSORB) begin
      block_bytes[fill] = data;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end else begin
      block_bytes[fill] = 8'h80;
      for (j = fill + 1; j < 64; j++)
        block_bytes[j] = 8'h00;
      // no room for the length field, spill into a second block
      if (fill > 55) begin
        compress();
        for (j = 0; j < 56; j++)
          block_bytes[j] = 8'h00;
      end
      for (j = 0; j < 8; j++)
        block_bytes[56+j] = 8'(msg_bits >> (56 - 8*j));
      compress();
      for (j = 0; j < 8; j++) begin
        dw.word = chain[j];
        dw.idx  = 3'(j);
        dw.last = (j == 7);
        pending_words.push_back(dw);
      end
      restart();
    end
  endfunction

  // accepted digest beat against the oldest expected word
  function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
    digest_word_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected digest word %h (index %0d, last %b)", $time, word, idx, last);
      errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    words_checked++;
    if (word !== exp_w.word) begin
      $display("%0t: digest_word mismatch, expected %h, got %h", $time, exp_w.word, word);
      errors++;
    end
    if (idx !== exp_w.idx) begin
      $display("%0t: word_index mismatch, expected %0d, got %0d", $time, exp_w.idx, idx);
      errors++;
    end
    if (last !== exp_w.last) begin
      $display("%0t: last_word mismatch, expected %b, got %b", $time, exp_w.last, last);
      errors++;
    end
  endfunction
endclass

module sha256_stream_hasher_test;

  localparam int StallLimit = 3000;
  localparam int SettleCycles = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard board = new();

  int unsigned beats_sent;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned longest_msg;

  sha256_stream_hasher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one beat from a falling edge and hold it until taken
  task automatic send_beat(input sha_pkg::cmd_t mode, input logic [7:0] data);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    board.note_beat(mode, data);
    beats_sent++;
    if (mode == sha_pkg::CMD_ABSORB)
      bytes_sent++;
    else
      messages_sent++;
    @(negedge clk);
  endtask

  // sender gap with junk on the payload
  task automatic idle_sender(input int unsigned cycles);
    in_valid     <= 1'b0;
    in_mode      <= 1'($urandom);
    in_data_byte <= 8'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // burst pacing: gaps between bursts, now and then a long burst with none
  task automatic pace();
    if (burst_left == 0) begin
      idle_sender(($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12));
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // hold off until every outstanding digest word has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input logic [7:0] fin_data);
    int unsigned k;
    logic [7:0] b;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      pace();
      send_beat(sha_pkg::CMD_ABSORB, b);
    end
    pace();
    send_beat(sha_pkg::CMD_FINISH, fin_data);
    if (len > longest_msg)
      longest_msg = len;
  endtask

  // digest side stall pattern: runs of free flow, random, sparse and toggling
  initial begin
    int unsigned style;
    int unsigned span;
    int unsigned k;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 150);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= k[0];
        endcase
      end
    end
  end

  // digest beats into the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_word(out_digest_word, out_word_index, out_last_word);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
      $display("sha256_stream_hasher regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, directed messages, random messages, settle, verdict
  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned edge_lens [8];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = 1'b0;
    in_data_byte = 8'h00;
    beats_sent    = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    burst_left    = 0;
    longest_msg   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message twice, finish byte all ones then all zeros
    send_beat(sha_pkg::CMD_FINISH, 8'hFF);
    send_beat(sha_pkg::CMD_FINISH, 8'h00);
    // "abc"
    send_beat(sha_pkg::CMD_ABSORB, 8'h61);
    send_beat(sha_pkg::CMD_ABSORB, 8'h62);
    send_beat(sha_pkg::CMD_ABSORB, 8'h63);
    send_beat(sha_pkg::CMD_FINISH, 8'hA5);
    // byte extremes, finish byte ignored
    send_beat(sha_pkg::CMD_ABSORB, 8'h00);
    send_beat(sha_pkg::CMD_ABSORB, 8'hFF);
    send_beat(sha_pkg::CMD_ABSORB, 8'h80);
    send_beat(sha_pkg::CMD_ABSORB, 8'h7F);
    send_beat(sha_pkg::CMD_FINISH, 8'h5A);
    drain();

    // random messages, mostly short, some around the padding boundaries
    while (beats_sent < 260 || messages_sent < 10) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        len = $urandom_range(0, 8);
      else if (pick < 7)
        len = edge_lens[$urandom_range(0, 7)];
      else
        len = $urandom_range(9, 70);
      // keep the total near the planned beat count
      if (beats_sent < 260 && beats_sent + len + 1 > 260)
        len = 260 - beats_sent - 1;
      send_message(len, 8'($urandom));
      if ($urandom_range(0, 5) == 0)
        drain();
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d beats: %0d bytes in %0d messages, longest %0d bytes",
             beats_sent, bytes_sent, messages_sent, longest_msg);
    $display("checked %0d digest words under random sender gaps and receiver stalls",
             board.words_checked);
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("sha256_stream_hasher regression: pass");
    end else begin
      $display("sha256_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule
